// File: design/reed_anemometer_speed_meter_core_defines.svh
// Assertion macros used by the checker file rasm_checker.sv.
`ifndef REED_ANEMOMETER_SPEED_METER_CORE_DEFINES_SVH
`define REED_ANEMOMETER_SPEED_METER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RASM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasm assertion failed");

// Next-cycle implication, disabled during reset
`define RASM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasm assertion failed");

`endif

// File: design/rasm_pkg.sv
package rasm_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EDGES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_PROBE     = 16'd2000;
  localparam logic [15:0] RST_WINDOW    = 16'd10000;
  localparam logic [7:0]  RST_MIN_EDGES = 8'd2;
  localparam logic [7:0]  RST_DEBOUNCE  = 8'd5;
  localparam logic [15:0] RST_FACTOR    = 16'd2731;
  localparam logic [15:0] RST_OFFSET    = 16'd0;

  // Datapath constants
  localparam logic [7:0]  SINCE_MAX = 8'hFF;
  localparam logic [15:0] TALLY_MAX = 16'hFFFF;
  localparam logic [15:0] SPEED_MAX = 16'hFFFF;
  localparam int unsigned MS_PER_S  = 1000;
  // factor * edges * 1000 stays below 2^42; the rounding term adds one bit
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned DVD_W     = 43;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PROBE,
    PH_WINDOW
  } phase_e;

  typedef enum logic [2:0] {
    ST_READY,
    ST_MUL,
    ST_SCALE,
    ST_DIV_INIT,
    ST_DIV,
    ST_ADJUST,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic advance;
    logic load_calm;
    logic mul;
    logic scale;
    logic div_init;
    logic div_step;
    logic adjust;
  } rasm_cmd_t;

  typedef struct packed {
    logic probe_done;
    logic window_done;
    logic below_min;
    logic div_last;
  } rasm_stat_t;

endpackage

// File: design/rasm_ctrl.sv
module rasm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_valid_i,
  input  logic                 start_req_i,
  input  logic                 out_free_i,
  input  rasm_pkg::rasm_stat_t stat_i,
  output logic                 tick_ready_o,
  output logic                 push_o,
  output rasm_pkg::rasm_cmd_t  cmd_o
);

  rasm_pkg::ctrl_state_e state_q, state_d;
  rasm_pkg::phase_e      phase_q, phase_d;
  logic                  accept;

  assign tick_ready_o = (state_q == rasm_pkg::ST_READY);
  assign accept       = tick_valid_i && tick_ready_o;

  // State and measurement phase registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rasm_pkg::ST_READY;
      phase_q <= rasm_pkg::PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      rasm_pkg::ST_READY: begin
        if (accept) begin
          if (start_req_i) begin
            phase_d = rasm_pkg::PH_PROBE;
          end else if (phase_q == rasm_pkg::PH_PROBE) begin
            if (stat_i.probe_done) begin
              if (stat_i.below_min) begin
                phase_d = rasm_pkg::PH_IDLE;
                state_d = rasm_pkg::ST_PUSH;
              end else if (stat_i.window_done) begin
                phase_d = rasm_pkg::PH_IDLE;
                state_d = rasm_pkg::ST_MUL;
              end else begin
                phase_d = rasm_pkg::PH_WINDOW;
              end
            end
          end else if (phase_q == rasm_pkg::PH_WINDOW && stat_i.window_done) begin
            phase_d = rasm_pkg::PH_IDLE;
            state_d = rasm_pkg::ST_MUL;
          end
        end
      end
      rasm_pkg::ST_MUL:      state_d = rasm_pkg::ST_SCALE;
      rasm_pkg::ST_SCALE:    state_d = rasm_pkg::ST_DIV_INIT;
      rasm_pkg::ST_DIV_INIT: state_d = rasm_pkg::ST_DIV;
      rasm_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = rasm_pkg::ST_ADJUST;
        end
      end
      rasm_pkg::ST_ADJUST:   state_d = rasm_pkg::ST_PUSH;
      rasm_pkg::ST_PUSH: begin
        if (out_free_i) begin
          state_d = rasm_pkg::ST_READY;
        end
      end
      default:               state_d = rasm_pkg::ST_READY;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o  = '0;
    push_o = 1'b0;
    case (state_q)
      rasm_pkg::ST_READY: begin
        if (accept) begin
          if (start_req_i) begin
            cmd_o.clear = 1'b1;
          end else if (phase_q == rasm_pkg::PH_PROBE || phase_q == rasm_pkg::PH_WINDOW) begin
            cmd_o.advance   = 1'b1;
            cmd_o.load_calm = (phase_q == rasm_pkg::PH_PROBE) && stat_i.probe_done &&
                              stat_i.below_min;
          end
        end
      end
      rasm_pkg::ST_MUL:      cmd_o.mul      = 1'b1;
      rasm_pkg::ST_SCALE:    cmd_o.scale    = 1'b1;
      rasm_pkg::ST_DIV_INIT: cmd_o.div_init = 1'b1;
      rasm_pkg::ST_DIV:      cmd_o.div_step = 1'b1;
      rasm_pkg::ST_ADJUST:   cmd_o.adjust   = 1'b1;
      rasm_pkg::ST_PUSH:     push_o         = out_free_i;
      default:               cmd_o          = '0;
    endcase
  end

endmodule

// File: design/rasm_dp.sv
module rasm_dp #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rasm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rasm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           reed_fall_i,
  input  rasm_pkg::rasm_cmd_t            cmd_i,
  output rasm_pkg::rasm_stat_t           stat_o,
  output logic [15:0]                    speed_o,
  output logic                           calm_o,
  output logic [15:0]                    edge_total_o
);

  localparam int unsigned DEN_W = TIME_BITS + 4;
  localparam int unsigned CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int unsigned CNT_W = $clog2(rasm_pkg::DVD_W);

  // Configuration registers
  logic [15:0] probe_q, window_q, factor_q, offset_q;
  logic [7:0]  min_edges_q, debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q     <= rasm_pkg::RST_PROBE;
      window_q    <= rasm_pkg::RST_WINDOW;
      min_edges_q <= rasm_pkg::RST_MIN_EDGES;
      debounce_q  <= rasm_pkg::RST_DEBOUNCE;
      factor_q    <= rasm_pkg::RST_FACTOR;
      offset_q    <= rasm_pkg::RST_OFFSET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rasm_pkg::CFG_PROBE:     probe_q     <= cfg_wdata_i;
        rasm_pkg::CFG_WINDOW:    window_q    <= cfg_wdata_i;
        rasm_pkg::CFG_MIN_EDGES: min_edges_q <= cfg_wdata_i[7:0];
        rasm_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_wdata_i[7:0];
        rasm_pkg::CFG_FACTOR:    factor_q    <= cfg_wdata_i;
        rasm_pkg::CFG_OFFSET:    offset_q    <= cfg_wdata_i;
        default:                 ;
      endcase
    end
  end

  // Measurement counters
  logic [TIME_BITS-1:0] elapsed_q, elapsed_inc;
  logic [15:0]          tally_q, tally_inc;
  logic [7:0]           since_q, since_inc;
  logic                 count_edge;

  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign since_inc   = (since_q == rasm_pkg::SINCE_MAX) ? since_q : since_q + 8'd1;
  assign count_edge  = reed_fall_i && (since_inc >= debounce_q);
  assign tally_inc   = (count_edge && tally_q != rasm_pkg::TALLY_MAX) ? tally_q + 16'd1
                                                                       : tally_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      tally_q   <= '0;
      since_q   <= rasm_pkg::SINCE_MAX;
    end else if (cmd_i.clear) begin
      elapsed_q <= '0;
      tally_q   <= '0;
      since_q   <= rasm_pkg::SINCE_MAX;
    end else if (cmd_i.advance) begin
      elapsed_q <= elapsed_inc;
      tally_q   <= tally_inc;
      since_q   <= count_edge ? 8'd0 : since_inc;
    end
  end

  // End tests; a target beyond the elapsed range is met at saturation
  assign stat_o.probe_done  = (CMP_W'(elapsed_inc) >= CMP_W'(probe_q)) || (&elapsed_inc);
  assign stat_o.window_done = (CMP_W'(elapsed_inc) >= CMP_W'(window_q)) || (&elapsed_inc);
  assign stat_o.below_min   = (tally_inc < {8'd0, min_edges_q});

  // Speed arithmetic: two multiply steps, a rounding add, then a restoring divider one bit per cycle
  logic [rasm_pkg::PROD_W-1:0] prod_q;
  logic [rasm_pkg::DVD_W-1:0]  dvd_q;
  logic [DEN_W-1:0]            rem_q, den;
  logic [DEN_W:0]              rem_sh;
  logic                        fit;
  logic [CNT_W-1:0]            cnt_q;

  assign den    = {elapsed_q, 4'b0000};
  assign rem_sh = {rem_q, dvd_q[rasm_pkg::DVD_W-1]};
  assign fit    = (rem_sh >= {1'b0, den});
  assign stat_o.div_last = (cnt_q == CNT_W'(rasm_pkg::DVD_W - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= rasm_pkg::PROD_W'(factor_q) * rasm_pkg::PROD_W'(tally_q);
    end
    if (cmd_i.scale) begin
      dvd_q <= rasm_pkg::DVD_W'(prod_q) * rasm_pkg::DVD_W'(rasm_pkg::MS_PER_S);
    end else if (cmd_i.div_init) begin
      // half the divisor for round half up
      dvd_q <= dvd_q + rasm_pkg::DVD_W'({elapsed_q, 3'b000});
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[rasm_pkg::DVD_W-2:0], fit};
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= DEN_W'(fit ? rem_sh - {1'b0, den} : rem_sh);
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Offset and clamp
  logic [16:0]        q_clip;
  logic signed [18:0] sum;
  logic [15:0]        speed_final;

  assign q_clip = (|dvd_q[rasm_pkg::DVD_W-1:17]) ? 17'h1FFFF : dvd_q[16:0];
  assign sum    = $signed({2'b00, q_clip}) + $signed({{3{offset_q[15]}}, offset_q});

  always_comb begin
    if (sum[18]) begin
      speed_final = '0;
    end else if (|sum[17:16]) begin
      speed_final = rasm_pkg::SPEED_MAX;
    end else begin
      speed_final = sum[15:0];
    end
  end

  // Result registers
  logic [15:0] speed_q, total_q;
  logic        calm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_calm) begin
      speed_q <= '0;
      calm_q  <= 1'b1;
      total_q <= tally_inc;
    end else if (cmd_i.adjust) begin
      speed_q <= speed_final;
      calm_q  <= 1'b0;
      total_q <= tally_q;
    end
  end

  assign speed_o      = speed_q;
  assign calm_o       = calm_q;
  assign edge_total_o = total_q;

endmodule

// File: design/reed_anemometer_speed_meter_core.sv
// Cup anemometer speed meter. Each input transfer is one millisecond tick carrying a start
// request and a debounced-candidate reed falling edge. The tick that closes a probe with too
// few edges yields a calm result and holds s_axis_tready low through the hand-off to the
// output register; the tick that closes the averaging window holds it low through two
// multiply steps, the rounding add, 43 steps of the bit-serial divider, offset/clamp and
// the hand-off to the output register. A result waits in the output register while further
// ticks are taken; if it is still waiting when the next result is ready, s_axis_tready stays
// low until it is taken.
module reed_anemometer_speed_meter_core #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: [0] start_req, [1] reed_fall, [7:2] zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,
  // tdata: [15:0] speed, [31:16] edge_total
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,
  // tuser: [0] calm
  output logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [rasm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rasm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  rasm_pkg::rasm_cmd_t  cmd;
  rasm_pkg::rasm_stat_t stat;
  logic                 push, out_free;
  logic [15:0]          speed, edge_total;
  logic                 calm;

  rasm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (s_axis_tvalid),
    .start_req_i  (s_axis_tdata[0]),
    .out_free_i   (out_free),
    .stat_i       (stat),
    .tick_ready_o (s_axis_tready),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  rasm_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .reed_fall_i  (s_axis_tdata[1]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .speed_o      (speed),
    .calm_o       (calm),
    .edge_total_o (edge_total)
  );

  // Output register
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic        m_user_q;

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_data_q <= {edge_total, speed};
      m_user_q <= calm;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: design/rasm_checker.sv
`include "reed_anemometer_speed_meter_core_defines.svh"

module rasm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A waiting result stays offered
  `RASM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A waiting result keeps its payload
  `RASM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Calm results carry zero speed
  `RASM_ASSERT_NOW(a_calm_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:0] == 16'd0)

  // Calm means fewer edges than an 8-bit minimum
  `RASM_ASSERT_NOW(a_calm_count, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:24] == 8'd0)

  // A start tick starts no computation
  `RASM_ASSERT_NEXT(a_start_ready, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tdata[0], s_axis_tready)

endmodule

bind reed_anemometer_speed_meter_core rasm_checker u_rasm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
